FILE: src/bsnd_pkg.sv
// Package for the block-scaled nibble sample decoder: defaults, item type, attenuation function.
`default_nettype none
package bsnd_pkg;

  localparam int GROUPS_PER_CHUNK_DEF = 3;
  localparam int WORDS_PER_GROUP_DEF  = 4;

  localparam int WORD_W   = 16;
  localparam int LEVEL_W  = 5;
  localparam int GLEVEL_W = 6;
  localparam int SAMPLE_W = 16;
  localparam int FIELD_LO = 5;

  typedef struct packed {
    logic [WORD_W-1:0]   nibbles;
    logic [GLEVEL_W-1:0] level;
    logic                chunk_end;
  } bsnd_word_t;

  // magnitude * 4096 * 2^(-r/4), truncated
  function automatic logic [15:0] bsnd_base(input logic [1:0] r, input logic [3:0] mag);
    logic [15:0] v;
    case ({r, mag})
      6'h01: v = 16'd4096;
      6'h02: v = 16'd8192;
      6'h03: v = 16'd12288;
      6'h04: v = 16'd16384;
      6'h05: v = 16'd20480;
      6'h06: v = 16'd24576;
      6'h07: v = 16'd28672;
      6'h08: v = 16'd32768;
      6'h11: v = 16'd3444;
      6'h12: v = 16'd6888;
      6'h13: v = 16'd10332;
      6'h14: v = 16'd13777;
      6'h15: v = 16'd17221;
      6'h16: v = 16'd20665;
      6'h17: v = 16'd24110;
      6'h18: v = 16'd27554;
      6'h21: v = 16'd2896;
      6'h22: v = 16'd5792;
      6'h23: v = 16'd8688;
      6'h24: v = 16'd11585;
      6'h25: v = 16'd14481;
      6'h26: v = 16'd17377;
      6'h27: v = 16'd20274;
      6'h28: v = 16'd23170;
      6'h31: v = 16'd2435;
      6'h32: v = 16'd4870;
      6'h33: v = 16'd7306;
      6'h34: v = 16'd9741;
      6'h35: v = 16'd12177;
      6'h36: v = 16'd14612;
      6'h37: v = 16'd17048;
      6'h38: v = 16'd19483;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] bsnd_atten(input logic [GLEVEL_W-1:0] lvl,
                                                     input logic [3:0] nib);
    logic [3:0]  mag;
    logic [15:0] m;
    mag = nib[3] ? (4'd0 - nib) : nib;
    m   = bsnd_base(lvl[1:0], mag) >> lvl[5:2];
    return nib[3] ? (~m + 16'd1) : m;
  endfunction

endpackage
`default_nettype wire

FILE: src/block_scaled_nibble_sample_decoder.sv
// Top level of the block-scaled nibble sample decoder.
// A header request (in_tuser = 1) loads the three attenuation fields and the voice level and
// yields no sample. A data request yields four signed samples, lowest nibble first, one per
// cycle while out_tready does not hold the output register. A word enters the word register
// on acceptance, and its first sample then moves to the output register once that register
// can advance. The next word is taken in the cycle its fourth sample moves to the output
// register. Attenuation entries are computed from a 32-entry quarter-step table and a shift,
// so there is no ROM and no startup pass.
`default_nettype none
module block_scaled_nibble_sample_decoder #(
  parameter int GROUPS_PER_CHUNK = bsnd_pkg::GROUPS_PER_CHUNK_DEF,
  parameter int WORDS_PER_GROUP  = bsnd_pkg::WORDS_PER_GROUP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // word [15:0], voice_level [20:16], zero [23:21]
  input  wire logic [0:0]  in_tuser,   // is_header
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // sample
  output logic             out_tlast,  // last_of_chunk
  output logic [0:0]       out_tuser   // last_of_word
);

  logic                 accept;
  logic                 slot_ready;
  bsnd_pkg::bsnd_word_t item;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = slot_ready;

  bsnd_front #(
    .GROUPS_PER_CHUNK (GROUPS_PER_CHUNK),
    .WORDS_PER_GROUP  (WORDS_PER_GROUP)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .is_header   (in_tuser[0]),
    .word        (in_tdata[15:0]),
    .voice_level (in_tdata[20:16]),
    .item        (item)
  );

  bsnd_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (accept && !in_tuser[0]),
    .item       (item),
    .slot_ready (slot_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

FILE: src/bsnd_front.sv
// Chunk state: header fields, level, word and group counters, per-word group level.
`default_nettype none
module bsnd_front #(
  parameter int GROUPS_PER_CHUNK = bsnd_pkg::GROUPS_PER_CHUNK_DEF,
  parameter int WORDS_PER_GROUP  = bsnd_pkg::WORDS_PER_GROUP_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic                          is_header,
  input  wire logic [bsnd_pkg::WORD_W-1:0]   word,
  input  wire logic [bsnd_pkg::LEVEL_W-1:0]  voice_level,
  output bsnd_pkg::bsnd_word_t               item
);

  localparam int WCW = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;
  localparam int GCW = (GROUPS_PER_CHUNK > 1) ? $clog2(GROUPS_PER_CHUNK) : 1;
  localparam logic [WCW-1:0] WC_LAST = WCW'(WORDS_PER_GROUP - 1);
  localparam logic [GCW-1:0] GC_LAST = GCW'(GROUPS_PER_CHUNK - 1);

  logic [bsnd_pkg::WORD_W-1:0]   fields_r, fields_nxt;
  logic [bsnd_pkg::LEVEL_W-1:0]  held_r, held_nxt;
  logic [bsnd_pkg::GLEVEL_W-1:0] glevel_r, glevel_nxt;
  logic [WCW-1:0]                wc_r, wc_nxt;
  logic [GCW-1:0]                gc_r, gc_nxt;
  logic [bsnd_pkg::GLEVEL_W-1:0] new_level;
  logic                          last_word, last_group;

  assign new_level  = bsnd_pkg::GLEVEL_W'(held_r)
                    + bsnd_pkg::GLEVEL_W'(fields_r[bsnd_pkg::FIELD_LO +: bsnd_pkg::LEVEL_W]);
  assign last_word  = (wc_r >= WC_LAST);
  assign last_group = (gc_r >= GC_LAST);

  assign item.nibbles   = word;
  assign item.level     = (wc_r == '0) ? new_level : glevel_r;
  assign item.chunk_end = last_word && last_group;

  always_comb begin
    fields_nxt = fields_r;
    held_nxt   = held_r;
    glevel_nxt = glevel_r;
    wc_nxt     = wc_r;
    gc_nxt     = gc_r;
    if (accept && is_header) begin
      fields_nxt = word;
      held_nxt   = voice_level;
      wc_nxt     = '0;
      gc_nxt     = '0;
    end else if (accept) begin
      if (wc_r == '0) begin
        glevel_nxt = new_level;
        fields_nxt = {fields_r[4:0], fields_r[15:5]};
      end
      if (last_word) begin
        wc_nxt = '0;
        gc_nxt = last_group ? '0 : gc_r + 1'b1;
      end else begin
        wc_nxt = wc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_r <= '0;
      held_r   <= '0;
      glevel_r <= '0;
      wc_r     <= '0;
      gc_r     <= '0;
    end else begin
      fields_r <= fields_nxt;
      held_r   <= held_nxt;
      glevel_r <= glevel_nxt;
      wc_r     <= wc_nxt;
      gc_r     <= gc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/bsnd_serializer.sv
// Word and output registers: one attenuated sample per cycle unless stalled.
`default_nettype none
module bsnd_serializer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           take,
  input  wire bsnd_pkg::bsnd_word_t           item,
  output logic                                slot_ready,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [bsnd_pkg::SAMPLE_W-1:0]       out_tdata,   // sample
  output logic                                out_tlast,   // last_of_chunk
  output logic [0:0]                          out_tuser    // last_of_word
);

  bsnd_pkg::bsnd_word_t              wrd_r;
  logic                              wrd_vld_r, wrd_vld_nxt;
  logic [1:0]                        k_r, k_nxt;
  logic                              ovld_r, ovld_nxt;
  logic [bsnd_pkg::SAMPLE_W-1:0]     sample_r;
  logic                              lw_r, lc_r;
  logic                              adv, emit, k_end;
  logic [3:0]                        nib;

  assign adv        = !ovld_r || out_tready;
  assign emit       = adv && wrd_vld_r;
  assign k_end      = (k_r == 2'd3);
  assign slot_ready = !wrd_vld_r || (emit && k_end);
  assign nib        = wrd_r.nibbles[{k_r, 2'b00} +: 4];

  always_comb begin
    wrd_vld_nxt = wrd_vld_r;
    k_nxt       = k_r;
    ovld_nxt    = ovld_r;
    if (adv) begin
      ovld_nxt = wrd_vld_r;
    end
    if (emit) begin
      k_nxt = k_r + 2'd1;
      if (k_end) begin
        wrd_vld_nxt = 1'b0;
      end
    end
    if (take) begin
      wrd_vld_nxt = 1'b1;
      k_nxt       = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrd_vld_r <= 1'b0;
      k_r       <= 2'd0;
      ovld_r    <= 1'b0;
    end else begin
      wrd_vld_r <= wrd_vld_nxt;
      k_r       <= k_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wrd_r <= item;
    end
    if (emit) begin
      sample_r <= bsnd_pkg::bsnd_atten(wrd_r.level, nib);
      lw_r     <= k_end;
      lc_r     <= k_end && wrd_r.chunk_end;
    end
  end

  assign out_tvalid   = ovld_r;
  assign out_tdata    = sample_r;
  assign out_tlast    = lc_r;
  assign out_tuser[0] = lw_r;

  a_chunk_on_word_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("chunk end flagged away from a word end");

  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    !slot_ready |-> wrd_vld_r)
    else $error("input stalled with an empty word slot");

  a_midword_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != 2'd0) |-> wrd_vld_r)
    else $error("sample index advanced without a word");

  a_slot_drains: assert property (@(posedge clk) disable iff (!rst_n)
    emit && k_end && !take |=> !wrd_vld_r && out_tvalid && out_tuser[0])
    else $error("word slot not released after its fourth sample");

endmodule
`default_nettype wire
